FILE: sv/eqd_pkg.sv
// package for the expiry deadline queue: command, status and register codes,
// field widths and the control struct shared by the top level and the cells
`default_nettype none
package eqd_pkg;

  localparam int unsigned SLOTS_DEF       = 32;
  localparam int unsigned TARGET_BITS_DEF = 16;
  localparam int unsigned SLOT_W          = 5;
  localparam int unsigned NOW_W           = 48;
  localparam int unsigned EXP_W           = 49;
  localparam int unsigned FIRE_W          = 50;
  localparam int unsigned CFG_W           = 32;

  localparam logic [31:0] LIFE_RESET  = 32'(60 * 1000);
  localparam logic [31:0] BATCH_RESET = 32'(5 * 1000);

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_REM   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_FLUSH   = 2'd2,
    ST_ERROR   = 2'd3
  } status_e;

  typedef enum logic {
    REG_LIFE  = 1'b0,
    REG_BATCH = 1'b1
  } reg_e;

  typedef struct packed {
    logic              shift;
    logic              scan;
    logic              kill;
    logic [SLOT_W-1:0] kill_slot;
    logic [NOW_W-1:0]  now;
  } ctl_t;

endpackage
`default_nettype wire

FILE: sv/expiry_deadline_queue_unit.sv
// top level of the expiry deadline queue: command decode, sequencer, result
// register and the row of eqd_cell positions; uses eqd_pkg
//
// The queue is a row of cells in enqueue order with the head in cell 0. Enqueue,
// rejected commands and ticks that do not fire are answered from idle; enqueue
// into an empty queue and remove of the head pass a schedule state. A removal
// leaves a hole that moves one cell a cycle toward the tail, so the next command
// waits until the row is compact. A firing tick ripples the due mark down the
// row in a scan state, picks the new fire time in a finish state, then pops one
// expired entry per cycle while the consumer is ready, as a flush does. Results
// leave through an output register, one per cycle while the consumer is ready.
`default_nettype none
module expiry_deadline_queue_unit #(
  parameter int unsigned SLOTS       = eqd_pkg::SLOTS_DEF,
  parameter int unsigned TARGET_BITS = eqd_pkg::TARGET_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [eqd_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   command_i,
  input  wire logic [eqd_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [15:0]                  target_id_i,
  input  wire logic [eqd_pkg::NOW_W-1:0]    now_ms_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        status_o,
  output logic [eqd_pkg::SLOT_W-1:0]        out_slot_o,
  output logic [15:0]                       out_target_o,
  output logic                              last_o,
  output logic                              armed_o,
  output logic [eqd_pkg::EXP_W-1:0]         fire_at_ms_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_SCHED = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [31:0]                 life_q, batch_q;
  logic [SLOTS-1:0]            mask_q, mask_d;
  logic [CW-1:0]               count_q, count_d;
  logic                        armed_q, armed_d;
  logic [eqd_pkg::FIRE_W-1:0]  fire_q, fire_d;
  logic [IW-1:0]               scnt_q, scnt_d;
  logic [eqd_pkg::NOW_W-1:0]   now_q, now_d;
  logic [1:0]                  pst_q, pst_d;

  logic                        ov_q, ov_d, olast_q, olast_d, oarm_q, oarm_d;
  logic [1:0]                  ost_q, ost_d;
  logic [eqd_pkg::SLOT_W-1:0]  oslot_q, oslot_d;
  logic [15:0]                 otgt_q, otgt_d;
  logic [eqd_pkg::EXP_W-1:0]   ofire_q, ofire_d;

  eqd_pkg::ctl_t               ctl;
  logic [SLOTS-1:0]            load;
  logic                        vld [SLOTS];
  logic                        run [SLOTS];
  logic [eqd_pkg::SLOT_W-1:0]  cslot [SLOTS];
  logic [eqd_pkg::EXP_W-1:0]   cexp [SLOTS];
  logic [TARGET_BITS-1:0]      ctgt [SLOTS];
  logic [eqd_pkg::EXP_W-1:0]   enq_exp;

  logic                        out_free, accept, compact, slot_bad, in_mask;
  logic [IW-1:0]               sidx;
  logic                        hv, fv;
  logic [eqd_pkg::EXP_W-1:0]   hexp, fexp;
  logic [eqd_pkg::FIRE_W-1:0]  hfire, ffire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q  <= eqd_pkg::LIFE_RESET;
      batch_q <= eqd_pkg::BATCH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        eqd_pkg::REG_LIFE:  life_q  <= cfg_data_i;
        eqd_pkg::REG_BATCH: batch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    compact = 1'b1;
    for (int i = 0; i < SLOTS - 1; i++) begin
      if (!vld[i] && vld[i+1]) compact = 1'b0;
    end
  end

  // head after a head change: cell 1 holds it while the hole sits in cell 0
  assign hv    = vld[0] || vld[1];
  assign hexp  = vld[0] ? cexp[0] : cexp[1];
  assign hfire = hv ? eqd_pkg::FIRE_W'(hexp) + eqd_pkg::FIRE_W'(batch_q) : '0;

  // first entry that stays after the due run
  always_comb begin
    fv   = 1'b0;
    fexp = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((i == 0 || run[i == 0 ? 0 : i-1]) && !run[i] && vld[i]) begin
        fv   = 1'b1;
        fexp = fexp | cexp[i];
      end
    end
  end
  assign ffire = fv ? eqd_pkg::FIRE_W'(fexp) + eqd_pkg::FIRE_W'(batch_q) : '0;

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && compact && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_bad   = 32'(slot_i) >= 32'(SLOTS);
  assign sidx       = IW'(slot_i);
  assign in_mask    = mask_q[sidx];
  assign enq_exp    = eqd_pkg::EXP_W'(now_ms_i) + eqd_pkg::EXP_W'(life_q);

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    count_d = count_q;
    armed_d = armed_q;
    fire_d  = fire_q;
    scnt_d  = scnt_q;
    now_d   = now_q;
    pst_d   = pst_q;
    ov_d    = ov_q && !out_ready_i;
    ost_d   = ost_q;
    oslot_d = oslot_q;
    otgt_d  = otgt_q;
    olast_d = olast_q;
    oarm_d  = oarm_q;
    ofire_d = ofire_q;
    ctl     = '0;
    ctl.now = now_q;
    ctl.kill_slot = slot_i;
    load    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ov_d    = 1'b1;
          ost_d   = eqd_pkg::ST_NONE;
          oslot_d = '0;
          otgt_d  = '0;
          olast_d = 1'b1;
          oarm_d  = armed_q;
          ofire_d = fire_q[eqd_pkg::EXP_W-1:0];
          unique case (command_i)
            eqd_pkg::CMD_ENQ: begin
              if (slot_bad || in_mask) begin
                ost_d = eqd_pkg::ST_ERROR;
              end else begin
                for (int i = 0; i < SLOTS; i++) load[i] = (count_q == CW'(i));
                mask_d[sidx] = 1'b1;
                count_d = count_q + 1'b1;
                if (count_q == '0) begin
                  ov_d    = 1'b0;
                  state_d = S_SCHED;
                end
              end
            end
            eqd_pkg::CMD_REM: begin
              if (slot_bad || !in_mask) begin
                ost_d = eqd_pkg::ST_ERROR;
              end else begin
                ctl.kill = 1'b1;
                mask_d[sidx] = 1'b0;
                count_d = count_q - 1'b1;
                if (cslot[0] == slot_i) begin
                  ov_d    = 1'b0;
                  state_d = S_SCHED;
                end
              end
            end
            eqd_pkg::CMD_TICK: begin
              if (armed_q && (eqd_pkg::FIRE_W'(now_ms_i) >= fire_q)) begin
                ov_d    = 1'b0;
                now_d   = now_ms_i;
                scnt_d  = '0;
                state_d = S_SCAN;
              end
            end
            eqd_pkg::CMD_FLUSH: begin
              armed_d = 1'b0;
              fire_d  = '0;
              oarm_d  = 1'b0;
              ofire_d = '0;
              if (count_q != '0) begin
                ov_d    = 1'b0;
                pst_d   = eqd_pkg::ST_FLUSH;
                state_d = S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        scnt_d   = scnt_q + 1'b1;
        if (scnt_q == IW'(SLOTS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        armed_d = fv;
        fire_d  = ffire;
        if (run[0]) begin
          pst_d   = eqd_pkg::ST_TIMEOUT;
          state_d = S_POP;
        end else if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = eqd_pkg::ST_NONE;
          oslot_d = '0;
          otgt_d  = '0;
          olast_d = 1'b1;
          oarm_d  = fv;
          ofire_d = ffire[eqd_pkg::EXP_W-1:0];
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          ov_d    = 1'b1;
          ost_d   = pst_q;
          oslot_d = cslot[0];
          otgt_d  = 16'(ctgt[0]);
          olast_d = (pst_q == eqd_pkg::ST_FLUSH) ? !vld[1] : !run[1];
          oarm_d  = armed_q;
          ofire_d = fire_q[eqd_pkg::EXP_W-1:0];
          mask_d[IW'(cslot[0])] = 1'b0;
          count_d = count_q - 1'b1;
          if (olast_d) state_d = S_IDLE;
        end
      end
      S_SCHED: begin
        armed_d = hv;
        fire_d  = hfire;
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = eqd_pkg::ST_NONE;
          oslot_d = '0;
          otgt_d  = '0;
          olast_d = 1'b1;
          oarm_d  = hv;
          ofire_d = hfire[eqd_pkg::EXP_W-1:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q  <= '0;
      count_q <= '0;
      armed_q <= 1'b0;
      fire_q  <= '0;
      scnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      count_q <= count_d;
      armed_q <= armed_d;
      fire_q  <= fire_d;
      scnt_q  <= scnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    pst_q   <= pst_d;
    ost_q   <= ost_d;
    oslot_q <= oslot_d;
    otgt_q  <= otgt_d;
    olast_q <= olast_d;
    oarm_q  <= oarm_d;
    ofire_q <= ofire_d;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic                       nbv, nbr, pvv, pvr;
    logic [eqd_pkg::SLOT_W-1:0] nbs;
    logic [eqd_pkg::EXP_W-1:0]  nbe;
    logic [TARGET_BITS-1:0]     nbt;
    if (g == SLOTS - 1) begin : g_end
      assign nbv = 1'b0;
      assign nbr = 1'b0;
      assign nbs = '0;
      assign nbe = '0;
      assign nbt = '0;
    end else begin : g_mid
      assign nbv = vld[g+1];
      assign nbr = run[g+1];
      assign nbs = cslot[g+1];
      assign nbe = cexp[g+1];
      assign nbt = ctgt[g+1];
    end
    if (g == 0) begin : g_first
      assign pvv = 1'b1;
      assign pvr = 1'b1;
    end else begin : g_rest
      assign pvv = vld[g-1];
      assign pvr = run[g-1];
    end
    eqd_cell #(.TARGET_BITS(TARGET_BITS)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .load_i     (load[g]),
      .ld_slot_i  (slot_i),
      .ld_exp_i   (enq_exp),
      .ld_tgt_i   (TARGET_BITS'(target_id_i)),
      .nb_valid_i (nbv),
      .nb_slot_i  (nbs),
      .nb_exp_i   (nbe),
      .nb_tgt_i   (nbt),
      .nb_run_i   (nbr),
      .pv_valid_i (pvv),
      .pv_run_i   (pvr),
      .valid_o    (vld[g]),
      .slot_o     (cslot[g]),
      .exp_o      (cexp[g]),
      .tgt_o      (ctgt[g]),
      .run_o      (run[g])
    );
  end

  assign out_valid_o  = ov_q;
  assign status_o     = ost_q;
  assign out_slot_o   = oslot_q;
  assign out_target_o = otgt_q;
  assign last_o       = olast_q;
  assign armed_o      = oarm_q;
  assign fire_at_ms_o = ofire_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(SLOTS))
    else $error("entry count above slot count");

  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(mask_q)) == 32'(count_q))
    else $error("queued mask disagrees with entry count");

  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> vld[0])
    else $error("pop with empty head cell");

  a_disarm_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q == '0) |-> !armed_q)
    else $error("timer armed on empty queue");

endmodule
`default_nettype wire

FILE: sv/eqd_cell.sv
// one queue position: slot, expiry, target, valid and run flag, passed toward the head
// uses eqd_pkg for widths and the broadcast control struct
`default_nettype none
module eqd_cell #(
  parameter int unsigned TARGET_BITS = eqd_pkg::TARGET_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire eqd_pkg::ctl_t                ctl_i,
  input  wire logic                         load_i,
  input  wire logic [eqd_pkg::SLOT_W-1:0]   ld_slot_i,
  input  wire logic [eqd_pkg::EXP_W-1:0]    ld_exp_i,
  input  wire logic [TARGET_BITS-1:0]       ld_tgt_i,
  input  wire logic                         nb_valid_i,
  input  wire logic [eqd_pkg::SLOT_W-1:0]   nb_slot_i,
  input  wire logic [eqd_pkg::EXP_W-1:0]    nb_exp_i,
  input  wire logic [TARGET_BITS-1:0]       nb_tgt_i,
  input  wire logic                         nb_run_i,
  input  wire logic                         pv_valid_i,
  input  wire logic                         pv_run_i,
  output logic                              valid_o,
  output logic [eqd_pkg::SLOT_W-1:0]        slot_o,
  output logic [eqd_pkg::EXP_W-1:0]         exp_o,
  output logic [TARGET_BITS-1:0]            tgt_o,
  output logic                              run_o
);

  logic                       valid_q, valid_d, run_q, run_d;
  logic [eqd_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [eqd_pkg::EXP_W-1:0]  exp_q, exp_d;
  logic [TARGET_BITS-1:0]     tgt_q, tgt_d;
  logic                       due;

  assign due = valid_q && (exp_q <= eqd_pkg::EXP_W'(ctl_i.now));

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    exp_d   = exp_q;
    tgt_d   = tgt_q;
    run_d   = run_q;
    priority if (ctl_i.shift || !valid_q) begin
      valid_d = nb_valid_i;
      slot_d  = nb_slot_i;
      exp_d   = nb_exp_i;
      tgt_d   = nb_tgt_i;
      run_d   = nb_run_i;
    end else if (load_i) begin
      valid_d = 1'b1;
      slot_d  = ld_slot_i;
      exp_d   = ld_exp_i;
      tgt_d   = ld_tgt_i;
    end else if (ctl_i.kill && slot_q == ctl_i.kill_slot) begin
      valid_d = 1'b0;
    end else if (!pv_valid_i) begin
      valid_d = 1'b0;
    end
    if (ctl_i.scan) begin
      run_d = due && pv_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      valid_q <= load_i && !valid_q && !ctl_i.shift ? 1'b1 : valid_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && !valid_q && !ctl_i.shift) begin
      slot_q <= ld_slot_i;
      exp_q  <= ld_exp_i;
      tgt_q  <= ld_tgt_i;
    end else begin
      slot_q <= slot_d;
      exp_q  <= exp_d;
      tgt_q  <= tgt_d;
    end
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;
  assign exp_o   = exp_q;
  assign tgt_o   = tgt_q;
  assign run_o   = run_q;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for expiry_deadline_queue_unit: drives commands and register writes,
// predicts each result with a behavioral deadline queue and compares every field
// depends on eqd_pkg and the unit's port list
`default_nettype none
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [eqd_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] command_i = '0;
  logic [eqd_pkg::SLOT_W-1:0] slot_i = '0;
  logic [15:0] target_id_i = '0;
  logic [eqd_pkg::NOW_W-1:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [eqd_pkg::SLOT_W-1:0] out_slot_o;
  logic [15:0] out_target_o;
  logic last_o;
  logic armed_o;
  logic [eqd_pkg::EXP_W-1:0] fire_at_ms_o;

  expiry_deadline_queue_unit dut (.*);

  typedef struct packed {
    logic [1:0] status;
    logic [eqd_pkg::SLOT_W-1:0] slot;
    logic [15:0] target;
    logic last;
    logic armed;
    logic [eqd_pkg::EXP_W-1:0] fire_at;
  } expiry_rec_t;

  expiry_rec_t expected_q[$];
  int errors = 0;
  bit quiet_mode = 1'b0;
  int unsigned idle_pct = 28;

  // predictor state
  logic [31:0] life_ms, batch_ms;
  logic [4:0] nxt[32], prv[32];
  logic [eqd_pkg::EXP_W-1:0] exp_at[32];
  logic [15:0] tgt_at[32];
  logic [31:0] queued;
  int unsigned head, tail, count;
  logic armed;
  logic [eqd_pkg::FIRE_W-1:0] fire_time;
  logic [eqd_pkg::NOW_W-1:0] clock_ms;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void rearm();
    if (count == 0) begin
      armed = 1'b0;
      fire_time = '0;
    end else begin
      armed = 1'b1;
      fire_time = eqd_pkg::FIRE_W'(exp_at[head]) + eqd_pkg::FIRE_W'(batch_ms);
    end
  endfunction

  function automatic void unlink(int unsigned s);
    if (count <= 1) begin
      head = 0;
      tail = 0;
    end else if (s == head) begin
      head = 32'(nxt[s]);
    end else if (s == tail) begin
      tail = 32'(prv[s]);
    end else begin
      nxt[prv[s]] = nxt[s];
      prv[nxt[s]] = prv[s];
    end
    queued[s] = 1'b0;
    if (count > 0) count--;
  endfunction

  function automatic void predict_expiry(eqd_pkg::cmd_e cmd, int unsigned s,
                                         logic [15:0] t,
                                         logic [eqd_pkg::NOW_W-1:0] now);
    expiry_rec_t res[$];
    expiry_rec_t r;
    int unsigned h;
    r = '0;
    case (cmd)
      eqd_pkg::CMD_ENQ: begin
        if (queued[s]) begin
          r.status = eqd_pkg::ST_ERROR;
          res.push_back(r);
        end else begin
          exp_at[s] = eqd_pkg::EXP_W'(now) + eqd_pkg::EXP_W'(life_ms);
          tgt_at[s] = t;
          queued[s] = 1'b1;
          if (count == 0) begin
            head = s;
            tail = s;
            count = 1;
            rearm();
          end else begin
            nxt[tail] = 5'(s);
            prv[s] = 5'(tail);
            tail = s;
            count++;
          end
          res.push_back(r);
        end
      end
      eqd_pkg::CMD_REM: begin
        if (!queued[s]) begin
          r.status = eqd_pkg::ST_ERROR;
          res.push_back(r);
        end else begin
          h = head;
          unlink(s);
          if (s == h) rearm();
          res.push_back(r);
        end
      end
      eqd_pkg::CMD_TICK: begin
        if (armed && eqd_pkg::FIRE_W'(now) >= fire_time) begin
          while (count > 0 && exp_at[head] <= eqd_pkg::EXP_W'(now)) begin
            h = head;
            unlink(h);
            r.status = eqd_pkg::ST_TIMEOUT;
            r.slot = eqd_pkg::SLOT_W'(h);
            r.target = tgt_at[h];
            res.push_back(r);
          end
          rearm();
        end
        if (res.size() == 0) begin
          r = '0;
          res.push_back(r);
        end
      end
      default: begin
        while (count > 0) begin
          h = head;
          unlink(h);
          r.status = eqd_pkg::ST_FLUSH;
          r.slot = eqd_pkg::SLOT_W'(h);
          r.target = tgt_at[h];
          res.push_back(r);
        end
        queued = '0;
        head = 0;
        tail = 0;
        armed = 1'b0;
        fire_time = '0;
        if (res.size() == 0) begin
          r = '0;
          res.push_back(r);
        end
      end
    endcase
    foreach (res[i]) begin
      res[i].last = (i == res.size() - 1);
      res[i].armed = armed;
      res[i].fire_at = armed ? eqd_pkg::EXP_W'(fire_time) : '0;
      expected_q.push_back(res[i]);
    end
  endfunction

  function automatic bit gap();
    return !quiet_mode && ($urandom_range(99) < idle_pct);
  endfunction

  // valid stays up after the accepting edge until the next falling edge,
  // where the next call or drain() either replaces or drops it
  task automatic send_command(eqd_pkg::cmd_e cmd, int unsigned s, logic [15:0] t,
                              logic [eqd_pkg::NOW_W-1:0] now);
    @(negedge clk_i);
    if (gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (gap()) @(negedge clk_i);
    end
    command_i <= cmd;
    slot_i <= eqd_pkg::SLOT_W'(s);
    target_id_i <= t;
    now_ms_i <= now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_expiry(cmd, s, t, now);
  endtask

  task automatic drain();
    int guard = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(eqd_pkg::reg_e idx, logic [31:0] val);
    drain();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == eqd_pkg::REG_LIFE) life_ms = val;
    else batch_ms = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  initial begin
    expiry_rec_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++;
          end
          if (out_slot_o !== e.slot) begin
            $error("out_slot exp %0d got %0d", e.slot, out_slot_o); errors++;
          end
          if (out_target_o !== e.target) begin
            $error("out_target exp %0h got %0h", e.target, out_target_o); errors++;
          end
          if (last_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, last_o); errors++;
          end
          if (armed_o !== e.armed) begin
            $error("armed exp %0d got %0d", e.armed, armed_o); errors++;
          end
          if (fire_at_ms_o !== e.fire_at) begin
            $error("fire_at_ms exp %0h got %0h", e.fire_at, fire_at_ms_o); errors++;
          end
        end
      end
    end
  end

  // consumer stalls
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i <= !gap();
    end
  end

  task automatic test_directed();
    send_command(eqd_pkg::CMD_TICK, 0, 0, 0);
    send_command(eqd_pkg::CMD_FLUSH, 0, 0, 0);
    send_command(eqd_pkg::CMD_REM, 3, 0, 0);
    send_command(eqd_pkg::CMD_ENQ, 0, 16'h0000, 48'd100);
    send_command(eqd_pkg::CMD_ENQ, 0, 16'hffff, 48'd100);
    send_command(eqd_pkg::CMD_ENQ, 31, 16'hffff, 48'd200);
    send_command(eqd_pkg::CMD_ENQ, 7, 16'h5a5a, 48'd300);
    send_command(eqd_pkg::CMD_TICK, 0, 0, 48'd1000);
    send_command(eqd_pkg::CMD_TICK, 0, 0, 48'd65150);
    send_command(eqd_pkg::CMD_REM, 7, 0, 0);
    send_command(eqd_pkg::CMD_REM, 7, 0, 0);
    send_command(eqd_pkg::CMD_ENQ, 5, 16'h1234, 48'd50);
    send_command(eqd_pkg::CMD_REM, 31, 0, 0);
    send_command(eqd_pkg::CMD_TICK, 0, 0, 48'd70000);
    send_command(eqd_pkg::CMD_ENQ, 1, 16'h8000, {eqd_pkg::NOW_W{1'b1}});
    send_command(eqd_pkg::CMD_ENQ, 2, 16'h0001, 48'd10);
    send_command(eqd_pkg::CMD_TICK, 0, 0, {eqd_pkg::NOW_W{1'b1}});
    send_command(eqd_pkg::CMD_FLUSH, 0, 0, 0);
  endtask

  task automatic test_extreme_regs();
    write_reg(eqd_pkg::REG_LIFE, 32'hffffffff);
    write_reg(eqd_pkg::REG_BATCH, 32'hffffffff);
    send_command(eqd_pkg::CMD_ENQ, 9, 16'haaaa, {eqd_pkg::NOW_W{1'b1}});
    send_command(eqd_pkg::CMD_ENQ, 10, 16'h5555, 48'h0);
    send_command(eqd_pkg::CMD_TICK, 0, 0, {eqd_pkg::NOW_W{1'b1}});
    send_command(eqd_pkg::CMD_FLUSH, 0, 0, 0);
    write_reg(eqd_pkg::REG_LIFE, 32'h0);
    write_reg(eqd_pkg::REG_BATCH, 32'h0);
    send_command(eqd_pkg::CMD_ENQ, 3, 16'h00ff, 48'd500);
    send_command(eqd_pkg::CMD_ENQ, 4, 16'hff00, 48'd400);
    send_command(eqd_pkg::CMD_TICK, 0, 0, 48'd450);
    send_command(eqd_pkg::CMD_TICK, 0, 0, 48'd500);
    send_command(eqd_pkg::CMD_FLUSH, 0, 0, 0);
  endtask

  // mostly well-formed traffic on a moving clock, with some noise
  task automatic test_random(int unsigned n, logic [31:0] life, logic [31:0] batch);
    int unsigned s, k;
    logic [eqd_pkg::NOW_W-1:0] now;
    write_reg(eqd_pkg::REG_LIFE, life);
    write_reg(eqd_pkg::REG_BATCH, batch);
    for (int i = 0; i < n; i++) begin
      clock_ms += eqd_pkg::NOW_W'($urandom_range(life / 8 + 3));
      k = $urandom_range(99);
      s = $urandom_range(31);
      now = clock_ms;
      if ($urandom_range(49) == 0) now = eqd_pkg::NOW_W'({$urandom, $urandom});
      if (k < 45) begin
        for (int j = 0; j < 32 && queued[s]; j++) s = (s + 1) % 32;
        send_command(eqd_pkg::CMD_ENQ, s, 16'($urandom), now);
      end else if (k < 60) begin
        if (count > 0 && $urandom_range(3) != 0) s = (k & 1) ? head : tail;
        send_command(eqd_pkg::CMD_REM, s, 0, now);
      end else if (k < 97) begin
        send_command(eqd_pkg::CMD_TICK, s, 16'($urandom), now);
      end else begin
        send_command(eqd_pkg::CMD_FLUSH, s, 16'($urandom), now);
      end
    end
    send_command(eqd_pkg::CMD_FLUSH, 0, 0, 0);
  endtask

  initial begin
    life_ms = eqd_pkg::LIFE_RESET;
    batch_ms = eqd_pkg::BATCH_RESET;
    queued = '0;
    head = 0; tail = 0; count = 0;
    armed = 1'b0;
    fire_time = '0;
    clock_ms = 48'd1000;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_extreme_regs();
    test_random(140, 32'd40, 32'd5);
    quiet_mode = 1'b1;
    test_random(80, 32'd200, 32'd0);
    quiet_mode = 1'b0;
    test_random(110, eqd_pkg::LIFE_RESET, eqd_pkg::BATCH_RESET);
    test_random(60, 32'd1000, 32'd100000);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
